// ----- rtl/dal_pkg.sv -----
// ----------------------------------------------------------------------------
// dal_pkg
// Shared types and constants of the dashed anti-aliased line rasterizer.
// ----------------------------------------------------------------------------
package dal_pkg;

	// Default window size in pixels
	localparam int WinWidthDef  = 1536;
	localparam int WinHeightDef = 1170;

	// Dash mask after reset
	localparam logic [31:0] PatternReset = 32'hFFFF_FFFF;

	// Coverage: 0.5 plus radius 0.9 in Q.8, and full coverage
	localparam int AlphaBias = 358;
	localparam int AlphaOne  = 256;

	// Shared square root: 40-bit radicand, one result bit per step
	localparam int RadW      = 40;
	localparam int RootW     = RadW / 2 + 1;
	localparam int RootIter  = RadW / 2;
	// Divider: 50-bit dividend scaled by 2^14, 40 quotient bits
	localparam int NumW      = 50;
	localparam int DenW      = 25;
	localparam int QuoW      = 40;
	localparam int DivIter   = QuoW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOX,
		ST_LSQ,
		ST_LGO,
		ST_LROOT,
		ST_DIFF,
		ST_PROD,
		ST_MPROD,
		ST_SEL,
		ST_DIV,
		ST_DROOT,
		ST_TROOT,
		ST_EMIT
	} dal_state_t;

	typedef enum logic [2:0] {
		ROOT_LEN,
		ROOT_PA,
		ROOT_PB,
		ROOT_QUO,
		ROOT_DASH
	} dal_root_src_t;

	typedef struct packed {
		logic          load_ep;
		logic          build_box;
		logic          len_sq;
		logic          len_done;
		logic          diff;
		logic          prod;
		logic          mprod;
		logic          div_start;
		logic          root_start;
		dal_root_src_t root_src;
		logic          dist_done;
		logic          dash_done;
		logic          emit;
	} dal_cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic case_lo;
		logic case_hi;
		logic fin;
		logic out_free;
	} dal_status_t;

endpackage

// ----- rtl/dal_req_if.sv -----
// ----------------------------------------------------------------------------
// dal_req_if
// Request channel: start a line or tick out the next pixel.
// ----------------------------------------------------------------------------
interface dal_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [9:0] x_start;
	logic [9:0] y_start;
	logic [9:0] x_end;
	logic [9:0] y_end;

	modport source(output valid, req_type, x_start, y_start, x_end, y_end, input ready);
	modport sink(input valid, req_type, x_start, y_start, x_end, y_end, output ready);
endinterface

// ----- rtl/dal_pix_if.sv -----
// ----------------------------------------------------------------------------
// dal_pix_if
// Pixel channel: one word per emitted box pixel.
// ----------------------------------------------------------------------------
interface dal_pix_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] pix_x;
	logic signed [11:0] pix_y;
	logic [8:0]         alpha;
	logic               draw;
	logic               last;

	modport source(output valid, pix_x, pix_y, alpha, draw, last, input ready);
	modport sink(input valid, pix_x, pix_y, alpha, draw, last, output ready);
endinterface

// ----- rtl/dal_isqrt.sv -----
// ----------------------------------------------------------------------------
// dal_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dal_isqrt
	import dal_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RadW-1:0]  rad,
	output logic             done,
	output logic [RootW-1:0] root
);

	localparam int CntW = $clog2(RootIter);

	logic [RadW-1:0] n_q, r_q, b_q, rb;
	logic [CntW-1:0] cnt_q;
	logic            busy_q, done_q;

	assign rb = r_q + b_q;

	// Control: run a fixed number of steps, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(RootIter - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(RootIter - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath: subtract the trial square where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= rad;
			r_q <= '0;
			b_q <= RadW'(1) << (RadW - 2);
		end else if (busy_q) begin
			if (n_q >= rb) begin
				n_q <= n_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[RootW-1:0];

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("square root restarted while busy");

endmodule

// ----- rtl/dal_div.sv -----
// ----------------------------------------------------------------------------
// dal_div
// Restoring divider: (num * 2^14) / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dal_div
	import dal_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            done,
	output logic [QuoW-1:0] quo
);

	localparam int CntW = $clog2(DivIter);

	logic [DenW-1:0] rem_q, den_q;
	logic [QuoW-1:0] quo_q;
	logic [DenW:0]   sh;
	logic [CntW-1:0] cnt_q;
	logic            busy_q, done_q;

	assign sh = {rem_q, quo_q[QuoW-1]};

	// Control: count quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(DivIter - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DivIter - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath: upper dividend bits seed the remainder, low bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DenW'(num[NumW-1:QuoW-14]);
			quo_q <= {num[QuoW-15:0], 14'd0};
			den_q <= den;
		end else if (busy_q) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= DenW'(sh - {1'b0, den_q});
				quo_q <= {quo_q[QuoW-2:0], 1'b1};
			end else begin
				rem_q <= sh[DenW-1:0];
				quo_q <= {quo_q[QuoW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// ----- rtl/dal_datapath.sv -----
// ----------------------------------------------------------------------------
// dal_datapath
// Line setup, per-pixel distance and dash evaluation, output register.
// ----------------------------------------------------------------------------
module dal_datapath
	import dal_pkg::*;
#(
	parameter int WIN_WIDTH  = WinWidthDef,
	parameter int WIN_HEIGHT = WinHeightDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dal_cmd_t    cmd,
	output dal_status_t status,
	input  logic [9:0]  x_start,
	input  logic [9:0]  y_start,
	input  logic [9:0]  x_end,
	input  logic [9:0]  y_end,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	dal_pix_if.source   pix
);

	// Line setup state
	logic [11:0]        c_q [4];
	logic signed [11:0] x0_q, y0_q, x1_q, y1_q;
	logic [10:0]        ax_q, ay_q;
	logic signed [13:0] bax_q, bay_q;
	logic [24:0]        m_q;
	logic [21:0]        wsq_q, hsq_q;
	logic [31:0]        pattern_q, pat_lat_q;
	logic [4:0]         phase_q, start_phase_q;
	logic signed [11:0] cur_x_q, cur_y_q;

	// Per-pixel work registers
	logic signed [13:0] pax_q, pay_q, ex_q, ey_q;
	logic signed [12:0] dx_q, dy_q;
	logic signed [25:0] dot_q;
	logic [24:0]        pa2_q, pb2_q;
	logic [22:0]        dd2_q;
	logic [49:0]        mp1_q, mp2_q;
	logic               lo_q, hi_q;
	logic [RootW-1:0]   qd_q;
	logic [4:0]         td_q;

	// Output register
	logic               ov_q;
	logic signed [11:0] ox_q, oy_q;
	logic [8:0]         oa_q;
	logic               od_q, ol_q;

	// Shared units
	logic [RadW-1:0]  rad;
	logic [RootW-1:0] root;
	logic [QuoW-1:0]  quo;
	logic             root_done, div_done;

	// Box and setup terms
	logic [11:0]        minx, maxx, miny, maxy;
	logic [12:0]        maxx1, maxy1;
	logic signed [11:0] w, h;
	logic signed [27:0] bxx, byy;

	// Pixel terms
	logic signed [13:0] hx, hy;
	logic signed [27:0] p_dx, p_dy, s_ax, s_ay, s_ex, s_ey;
	logic signed [25:0] s_dx, s_dy;
	logic signed [51:0] dot_sq;
	logic [8:0]         alpha;
	logic               in_win, fin, bit_on;
	logic [4:0]         pidx;

	assign minx  = (c_q[0] < c_q[2]) ? c_q[0] : c_q[2];
	assign maxx  = (c_q[0] < c_q[2]) ? c_q[2] : c_q[0];
	assign miny  = (c_q[1] < c_q[3]) ? c_q[1] : c_q[3];
	assign maxy  = (c_q[1] < c_q[3]) ? c_q[3] : c_q[1];
	assign maxx1 = {1'b0, maxx} + 13'd1;
	assign maxy1 = {1'b0, maxy} + 13'd1;
	assign w     = x1_q - x0_q;
	assign h     = y1_q - y0_q;
	assign bxx   = bax_q * bax_q;
	assign byy   = bay_q * bay_q;

	assign hx     = {cur_x_q[11], cur_x_q, 1'b0};
	assign hy     = {cur_y_q[11], cur_y_q, 1'b0};
	assign p_dx   = pax_q * bax_q;
	assign p_dy   = pay_q * bay_q;
	assign s_ax   = pax_q * pax_q;
	assign s_ay   = pay_q * pay_q;
	assign s_ex   = ex_q * ex_q;
	assign s_ey   = ey_q * ey_q;
	assign s_dx   = dx_q * dx_q;
	assign s_dy   = dy_q * dy_q;
	assign dot_sq = dot_q * dot_q;

	// Select the square root operand
	always_comb begin
		case (cmd.root_src)
			ROOT_LEN:  rad = RadW'({1'b0, wsq_q} + {1'b0, hsq_q});
			ROOT_PA:   rad = RadW'({pa2_q, 14'd0});
			ROOT_PB:   rad = RadW'({pb2_q, 14'd0});
			ROOT_QUO:  rad = quo;
			ROOT_DASH: rad = RadW'(dd2_q);
			default:   rad = '0;
		endcase
	end

	dal_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.rad    (rad),
		.done   (root_done),
		.root   (root)
	);

	dal_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (mp1_q - mp2_q),
		.den    (m_q),
		.done   (div_done),
		.quo    (quo)
	);

	// Coverage and dash bit of the current pixel
	always_comb begin
		if (qd_q >= RootW'(AlphaBias))
			alpha = '0;
		else if (qd_q < RootW'(AlphaBias - AlphaOne))
			alpha = 9'(AlphaOne);
		else
			alpha = 9'(RootW'(AlphaBias) - qd_q);
	end

	assign pidx   = start_phase_q + td_q;
	assign bit_on = pat_lat_q[pidx];
	assign in_win = !cur_x_q[11] && ({1'b0, cur_x_q} < 13'(WIN_WIDTH)) &&
	                !cur_y_q[11] && ({1'b0, cur_y_q} < 13'(WIN_HEIGHT));
	assign fin    = (cur_x_q >= x1_q) && (cur_y_q >= y1_q);

	// Control registers: pattern, dash phase, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= PatternReset;
			pat_lat_q     <= '0;
			phase_q       <= '0;
			start_phase_q <= '0;
			ov_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				pattern_q <= cfg_wdata;
				phase_q   <= '0;
			end else if (cmd.len_done) begin
				start_phase_q <= phase_q;
				phase_q       <= phase_q + root[4:0];
				pat_lat_q     <= pattern_q;
			end
			if (cmd.emit)
				ov_q <= 1'b1;
			else if (pix.ready)
				ov_q <= 1'b0;
		end
	end

	// Geometry registers, cleared by reset as idle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				c_q[i] <= '0;
			x0_q    <= '0;
			y0_q    <= '0;
			x1_q    <= '0;
			y1_q    <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			// Endpoints scaled by three (x + 2x)
			if (cmd.load_ep) begin
				c_q[0] <= {2'b0, x_start} + {1'b0, x_start, 1'b0};
				c_q[1] <= {2'b0, y_start} + {1'b0, y_start, 1'b0};
				c_q[2] <= {2'b0, x_end} + {1'b0, x_end, 1'b0};
				c_q[3] <= {2'b0, y_end} + {1'b0, y_end, 1'b0};
			end
			// Padded box and anchor
			if (cmd.build_box) begin
				x0_q <= $signed({1'b0, minx[11:1]}) - 12'sd1;
				y0_q <= $signed({1'b0, miny[11:1]}) - 12'sd1;
				x1_q <= $signed(maxx1[12:1]) + 12'sd1;
				y1_q <= $signed(maxy1[12:1]) + 12'sd1;
				ax_q <= c_q[0][11:1];
				ay_q <= c_q[1][11:1];
			end
			// Cursor: box origin at start, raster order on emit
			if (cmd.len_done) begin
				cur_x_q <= x0_q;
				cur_y_q <= y0_q;
			end else if (cmd.emit && !fin) begin
				if (cur_x_q >= x1_q) begin
					cur_x_q <= x0_q;
					cur_y_q <= cur_y_q + 12'sd1;
				end else begin
					cur_x_q <= cur_x_q + 12'sd1;
				end
			end
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		if (cmd.build_box) begin
			bax_q <= $signed({2'b0, c_q[2]}) - $signed({2'b0, c_q[0]});
			bay_q <= $signed({2'b0, c_q[3]}) - $signed({2'b0, c_q[1]});
		end
		if (cmd.len_sq) begin
			wsq_q <= w[10:0] * w[10:0];
			hsq_q <= h[10:0] * h[10:0];
			m_q   <= {1'b0, bxx[23:0]} + {1'b0, byy[23:0]};
		end
		if (cmd.diff) begin
			pax_q <= hx - $signed({2'b0, c_q[0]});
			pay_q <= hy - $signed({2'b0, c_q[1]});
			ex_q  <= hx - $signed({2'b0, c_q[2]});
			ey_q  <= hy - $signed({2'b0, c_q[3]});
			dx_q  <= $signed({cur_x_q[11], cur_x_q}) - $signed({2'b0, ax_q});
			dy_q  <= $signed({cur_y_q[11], cur_y_q}) - $signed({2'b0, ay_q});
		end
		if (cmd.prod) begin
			dot_q <= 26'(p_dx + p_dy);
			pa2_q <= {1'b0, s_ax[23:0]} + {1'b0, s_ay[23:0]};
			pb2_q <= {1'b0, s_ex[23:0]} + {1'b0, s_ey[23:0]};
			dd2_q <= {1'b0, s_dx[21:0]} + {1'b0, s_dy[21:0]};
		end
		if (cmd.mprod) begin
			mp1_q <= pa2_q * m_q;
			mp2_q <= dot_sq[49:0];
			lo_q  <= dot_q <= 26'sd0;
			hi_q  <= dot_q >= $signed({1'b0, m_q});
		end
		if (cmd.dist_done)
			qd_q <= root;
		if (cmd.dash_done)
			td_q <= root[4:0];
		if (cmd.emit) begin
			ox_q <= cur_x_q;
			oy_q <= cur_y_q;
			oa_q <= alpha;
			od_q <= bit_on && in_win;
			ol_q <= fin;
		end
	end

	assign pix.valid = ov_q;
	assign pix.pix_x = ox_q;
	assign pix.pix_y = oy_q;
	assign pix.alpha = oa_q;
	assign pix.draw  = od_q;
	assign pix.last  = ol_q;

	assign status.root_done = root_done;
	assign status.div_done  = div_done;
	assign status.case_lo   = lo_q;
	assign status.case_hi   = hi_q;
	assign status.fin       = fin;
	assign status.out_free  = !ov_q || pix.ready;

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!ov_q || pix.ready))
		else $error("pixel word overwritten before it was taken");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.root_start && cmd.div_start))
		else $error("divider and square root started together");

	a_cursor_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (cur_x_q >= x0_q && cur_x_q <= x1_q && cur_y_q <= y1_q))
		else $error("cursor left the bounding box");

endmodule

// ----- rtl/dal_ctrl.sv -----
// ----------------------------------------------------------------------------
// dal_ctrl
// Sequencer: line setup and the per-pixel steps through the shared units.
// ----------------------------------------------------------------------------
module dal_ctrl
	import dal_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_type,
	output logic        in_ready,
	input  dal_status_t status,
	output dal_cmd_t    cmd
);

	dal_state_t state_q, state_d;
	logic       active_q;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	// State and line-active flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.len_done)
				active_q <= 1'b1;
			else if (cmd.emit && status.fin)
				active_q <= 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && !in_type)
					state_d = ST_BOX;
				else if (acc && active_q)
					state_d = ST_DIFF;
			end
			ST_BOX:   state_d = ST_LSQ;
			ST_LSQ:   state_d = ST_LGO;
			ST_LGO:   state_d = ST_LROOT;
			ST_LROOT: if (status.root_done) state_d = ST_IDLE;
			ST_DIFF:  state_d = ST_PROD;
			ST_PROD:  state_d = ST_MPROD;
			ST_MPROD: state_d = ST_SEL;
			ST_SEL: begin
				if (status.case_lo || status.case_hi)
					state_d = ST_DROOT;
				else
					state_d = ST_DIV;
			end
			ST_DIV:   if (status.div_done) state_d = ST_DROOT;
			ST_DROOT: if (status.root_done) state_d = ST_TROOT;
			ST_TROOT: if (status.root_done) state_d = ST_EMIT;
			ST_EMIT:  if (status.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.root_src = ROOT_LEN;
		case (state_q)
			ST_IDLE:  cmd.load_ep = acc && !in_type;
			ST_BOX:   cmd.build_box = 1'b1;
			ST_LSQ:   cmd.len_sq = 1'b1;
			ST_LGO:   cmd.root_start = 1'b1;
			ST_LROOT: cmd.len_done = status.root_done;
			ST_DIFF:  cmd.diff = 1'b1;
			ST_PROD:  cmd.prod = 1'b1;
			ST_MPROD: cmd.mprod = 1'b1;
			ST_SEL: begin
				if (status.case_lo) begin
					cmd.root_start = 1'b1;
					cmd.root_src   = ROOT_PA;
				end else if (status.case_hi) begin
					cmd.root_start = 1'b1;
					cmd.root_src   = ROOT_PB;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.root_start = status.div_done;
				cmd.root_src   = ROOT_QUO;
			end
			ST_DROOT: begin
				cmd.dist_done  = status.root_done;
				cmd.root_start = status.root_done;
				cmd.root_src   = ROOT_DASH;
			end
			ST_TROOT: cmd.dash_done = status.root_done;
			ST_EMIT:  cmd.emit = status.out_free;
			default:  cmd = '0;
		endcase
	end

	a_start_to_box: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !in_type) |=> (state_q == ST_BOX))
		else $error("start word did not enter line setup");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && status.fin) |=> !active_q)
		else $error("line still active after its final pixel");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == ST_DIV))
		else $error("quotient arrived outside the divide step");

	a_root_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		status.root_done |-> (state_q == ST_LROOT || state_q == ST_DROOT ||
		                      state_q == ST_TROOT))
		else $error("square root finished outside a waiting step");

endmodule

// ----- rtl/dashed_aa_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// dashed_aa_line_rasterizer
// Dashed anti-aliased line rasterizer on a capsule distance field.
// ----------------------------------------------------------------------------
// A start word runs box setup, then one 20-step square root of the box
// diagonal that advances the dash phase. Each tick word yields one box
// pixel in raster order. A pixel that projects inside the segment uses the
// divider, then two 20-step square roots on the one shared root unit for
// distance and dash index; near the end caps the divider is skipped. The
// pixel word sits in an output register, so the next request is taken
// while it waits. A tick while no line is active is taken and gives no
// word. Writing line_pattern clears the dash phase; a line in progress
// keeps the pattern it latched at its start.
// ----------------------------------------------------------------------------
module dashed_aa_line_rasterizer
	import dal_pkg::*;
#(
	parameter int WIN_WIDTH  = WinWidthDef,
	parameter int WIN_HEIGHT = WinHeightDef
) (
	input  logic        clk,
	input  logic        arst_n,
	dal_req_if.sink     req,
	dal_pix_if.source   pix,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	dal_cmd_t    cmd;
	dal_status_t status;

	dal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.req_type),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dal_datapath #(
		.WIN_WIDTH  (WIN_WIDTH),
		.WIN_HEIGHT (WIN_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.x_start   (req.x_start),
		.y_start   (req.y_start),
		.x_end     (req.x_end),
		.y_end     (req.y_end),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pix       (pix)
	);

endmodule
